// ===== rtl/sdse_pkg.sv =====
// shared types and segment pattern tables for the signed decimal segment encoder
package sdse_pkg;

    localparam int NumBytes = 5;
    localparam int SegWidth = 7;
    localparam int ValueWidth = 13;
    localparam int ApbAddrWidth = 3;
    localparam int ApbDataWidth = 32;

    localparam logic [0:0] RegShowSign = 1'b0;

    typedef logic [SegWidth-1:0] t_seg;
    typedef t_seg [NumBytes-1:0] t_field;

    function automatic t_field mk(input t_seg b0, input t_seg b1, input t_seg b2,
                                  input t_seg b3, input t_seg b4);
        t_field f;
        f[0] = b0;
        f[1] = b1;
        f[2] = b2;
        f[3] = b3;
        f[4] = b4;
        return f;
    endfunction

    localparam t_field PatError = mk(7'd0, 7'd36, 7'd0, 7'd0, 7'd8);
    localparam t_field PatMinus = mk(7'd0, 7'd0, 7'd0, 7'd64, 7'd0);
    localparam t_field PatPlus  = mk(7'd0, 7'd0, 7'd64, 7'd64, 7'd0);
    localparam t_field PatLead1 = mk(7'd0, 7'd64, 7'd0, 7'd0, 7'd0);
    localparam t_field PatDot   = mk(7'd0, 7'd8, 7'd0, 7'd0, 7'd0);

    localparam t_field TabTens [10] = '{
        mk(7'd96, 7'd0,  7'd32, 7'd32, 7'd48), mk(7'd0,  7'd0,  7'd0,  7'd32, 7'd16),
        mk(7'd96, 7'd32, 7'd32, 7'd32, 7'd0),  mk(7'd96, 7'd32, 7'd0,  7'd32, 7'd16),
        mk(7'd0,  7'd32, 7'd0,  7'd32, 7'd48), mk(7'd96, 7'd32, 7'd0,  7'd0,  7'd48),
        mk(7'd96, 7'd32, 7'd32, 7'd0,  7'd48), mk(7'd64, 7'd0,  7'd0,  7'd32, 7'd16),
        mk(7'd96, 7'd32, 7'd32, 7'd32, 7'd48), mk(7'd96, 7'd32, 7'd0,  7'd32, 7'd48)
    };

    localparam t_field TabOnes [10] = '{
        mk(7'd16, 7'd16, 7'd24, 7'd24, 7'd0), mk(7'd0,  7'd16, 7'd8,  7'd0,  7'd0),
        mk(7'd16, 7'd16, 7'd0,  7'd24, 7'd8), mk(7'd0,  7'd16, 7'd8,  7'd24, 7'd8),
        mk(7'd0,  7'd16, 7'd24, 7'd0,  7'd8), mk(7'd0,  7'd0,  7'd24, 7'd24, 7'd8),
        mk(7'd16, 7'd0,  7'd24, 7'd24, 7'd8), mk(7'd0,  7'd16, 7'd8,  7'd16, 7'd0),
        mk(7'd16, 7'd16, 7'd24, 7'd24, 7'd8), mk(7'd0,  7'd16, 7'd24, 7'd24, 7'd8)
    };

    localparam t_field TabTenths [10] = '{
        mk(7'd12, 7'd0, 7'd4, 7'd4, 7'd6), mk(7'd0,  7'd0, 7'd0, 7'd4, 7'd2),
        mk(7'd12, 7'd4, 7'd4, 7'd4, 7'd0), mk(7'd12, 7'd4, 7'd0, 7'd4, 7'd2),
        mk(7'd0,  7'd4, 7'd0, 7'd4, 7'd6), mk(7'd12, 7'd4, 7'd0, 7'd0, 7'd6),
        mk(7'd12, 7'd4, 7'd4, 7'd0, 7'd6), mk(7'd8,  7'd0, 7'd0, 7'd4, 7'd2),
        mk(7'd12, 7'd4, 7'd4, 7'd4, 7'd6), mk(7'd12, 7'd4, 7'd0, 7'd4, 7'd6)
    };

endpackage

// ===== rtl/sdse_enc.sv =====
// combinational value to segment field encoder
module sdse_enc (
    input  logic signed [sdse_pkg::ValueWidth-1:0] i_value,
    input  logic                                   i_show_sign,
    output sdse_pkg::t_field                       o_field,
    output logic                                   o_out_of_range
);
    import sdse_pkg::*;

    logic                  w_neg;
    logic [ValueWidth-1:0] w_mag;
    logic [10:0]           w_mag_low;
    logic [9:0]            w_below_k;
    logic [20:0]           w_prod_h;
    logic [3:0]            w_dig_h;
    logic [6:0]            w_rem_h;
    logic [14:0]           w_prod_o;
    logic [3:0]            w_dig_o;
    logic [3:0]            w_dig_t;

    // digit split: hundreds by reciprocal 1311/2^17, tens by 205/2^11
    always_comb begin
        w_neg     = i_value[ValueWidth-1];
        w_mag     = w_neg ? ValueWidth'(-i_value) : ValueWidth'(i_value);
        w_mag_low = w_mag[10:0];
        w_below_k = (w_mag_low >= 11'd1000) ? 10'(w_mag_low - 11'd1000) : w_mag_low[9:0];
        w_prod_h  = 21'(w_below_k) * 21'd1311;
        w_dig_h   = w_prod_h[20:17];
        w_rem_h   = 7'(w_below_k - 10'(w_dig_h) * 10'd100);
        w_prod_o  = 15'(w_rem_h) * 15'd205;
        w_dig_o   = w_prod_o[14:11];
        w_dig_t   = 4'(w_rem_h - 7'(w_dig_o) * 7'd10);
    end

    always_comb begin
        o_field        = '0;
        o_out_of_range = 1'b0;
        if (i_show_sign) begin
            if (w_neg) begin
                o_field = o_field | PatMinus;
            end else if (w_mag != '0) begin
                o_field = o_field | PatPlus;
            end
        end
        if (w_mag > ValueWidth'(1999)) begin
            o_field        = o_field | PatError;
            o_out_of_range = 1'b1;
        end else begin
            if (w_mag >= ValueWidth'(1000)) begin
                o_field = o_field | PatLead1;
            end
            o_field = o_field | PatDot;
            if (w_mag >= ValueWidth'(100)) begin
                o_field = o_field | TabTens[w_dig_h];
            end
            if (w_mag >= ValueWidth'(10)) begin
                o_field = o_field | TabOnes[w_dig_o];
            end
            if (w_mag != '0) begin
                o_field = o_field | TabTenths[w_dig_t];
            end
        end
    end

endmodule

// ===== rtl/signed_decimal_segment_encoder.sv =====
// top level of the signed decimal segment encoder with apb register port
//
// channel   direction  handshake                 payload
// command   in         start && !busy            i_value_tenths
// result    out        o_valid (one cycle)       o_seg_byte0..4, o_out_of_range
// config    in         psel && penable && pwrite paddr, pwdata (show_sign at 0x0)
//
// one transaction per cycle; the result strobe is raised once an accepted value has passed
// the input register, the encoder logic and the result register
// busy is never raised, so back-to-back commands are taken every cycle
// synchronous active-low reset clears the valid flags and sets show_sign
// the receiver cannot stall; each result is shown for exactly one cycle
module signed_decimal_segment_encoder (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [sdse_pkg::ValueWidth-1:0]   i_value_tenths,
    output logic                                     o_valid,
    output logic [sdse_pkg::SegWidth-1:0]            o_seg_byte0,
    output logic [sdse_pkg::SegWidth-1:0]            o_seg_byte1,
    output logic [sdse_pkg::SegWidth-1:0]            o_seg_byte2,
    output logic [sdse_pkg::SegWidth-1:0]            o_seg_byte3,
    output logic [sdse_pkg::SegWidth-1:0]            o_seg_byte4,
    output logic                                     o_out_of_range,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [sdse_pkg::ApbAddrWidth-1:0]        paddr,
    input  logic [sdse_pkg::ApbDataWidth-1:0]        pwdata,
    output logic [sdse_pkg::ApbDataWidth-1:0]        prdata,
    output logic                                     pready
);
    import sdse_pkg::*;

    logic                         r_show_sign;
    logic                         n_show_sign;
    logic                         r_in_valid;
    logic signed [ValueWidth-1:0] r_value;
    logic                         r_out_valid;
    t_field                       r_field;
    logic                         r_oor;
    t_field                       w_field;
    logic                         w_oor;
    logic                         w_cfg_write;

    assign busy        = 1'b0;
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_show_sign = r_show_sign;
        if (w_cfg_write && (paddr[2] == RegShowSign)) begin
            n_show_sign = pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == RegShowSign) begin
            prdata = ApbDataWidth'(r_show_sign);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_sign <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_show_sign <= n_show_sign;
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_value <= i_value_tenths;
        end
        if (r_in_valid) begin
            r_field <= w_field;
            r_oor   <= w_oor;
        end
    end

    sdse_enc u_enc (
        .i_value        (r_value),
        .i_show_sign    (r_show_sign),
        .o_field        (w_field),
        .o_out_of_range (w_oor)
    );

    assign o_valid        = r_out_valid;
    assign o_seg_byte0    = r_field[0];
    assign o_seg_byte1    = r_field[1];
    assign o_seg_byte2    = r_field[2];
    assign o_seg_byte3    = r_field[3];
    assign o_seg_byte4    = r_field[4];
    assign o_out_of_range = r_oor;

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_valid)
        else $error("accepted transaction did not reach the result port");

    a_dot_vs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_seg_byte1[3] != o_out_of_range))
        else $error("dot and error flag disagree");

    a_plus_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_seg_byte2[6] |-> o_seg_byte3[6])
        else $error("plus sign drawn without its bar");

    a_sign_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_show_sign |=> !o_seg_byte3[6])
        else $error("sign drawn while sign display is off");

endmodule

// ===== bench/signed_decimal_segment_encoder_tb.sv =====
// self-checking testbench for the signed decimal segment encoder: directed table, then random
module signed_decimal_segment_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdse_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int NumPhases = 7;
    localparam int ItemsPerPhase = 155;
    localparam int NumRows = 23;
    localparam logic [ApbAddrWidth-1:0] ShowSignAddr = {RegShowSign, 2'b00};
    localparam logic [ApbAddrWidth-1:0] UnmappedAddr = 3'd4;

    typedef struct {
        t_seg bytes [NumBytes];
        logic oor;
    } t_display;

    typedef struct {
        int value;
        bit typed;
        int b0, b1, b2, b3, b4;
        bit oor;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic signed [ValueWidth-1:0]  i_value_tenths;
    logic                          o_valid;
    logic [SegWidth-1:0]           o_seg_byte0;
    logic [SegWidth-1:0]           o_seg_byte1;
    logic [SegWidth-1:0]           o_seg_byte2;
    logic [SegWidth-1:0]           o_seg_byte3;
    logic [SegWidth-1:0]           o_seg_byte4;
    logic                          o_out_of_range;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ApbAddrWidth-1:0]       paddr;
    logic [ApbDataWidth-1:0]       pwdata;
    logic [ApbDataWidth-1:0]       prdata;
    logic                          pready;

    signed_decimal_segment_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value_tenths (i_value_tenths),
        .o_valid        (o_valid),
        .o_seg_byte0    (o_seg_byte0),
        .o_seg_byte1    (o_seg_byte1),
        .o_seg_byte2    (o_seg_byte2),
        .o_seg_byte3    (o_seg_byte3),
        .o_seg_byte4    (o_seg_byte4),
        .o_out_of_range (o_out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    t_seg tens_glyph [10][NumBytes] = '{
        '{96, 0, 32, 32, 48}, '{0, 0, 0, 32, 16},  '{96, 32, 32, 32, 0},
        '{96, 32, 0, 32, 16}, '{0, 32, 0, 32, 48}, '{96, 32, 0, 0, 48},
        '{96, 32, 32, 0, 48}, '{64, 0, 0, 32, 16}, '{96, 32, 32, 32, 48},
        '{96, 32, 0, 32, 48}
    };

    t_seg ones_glyph [10][NumBytes] = '{
        '{16, 16, 24, 24, 0}, '{0, 16, 8, 0, 0},   '{16, 16, 0, 24, 8},
        '{0, 16, 8, 24, 8},   '{0, 16, 24, 0, 8},  '{0, 0, 24, 24, 8},
        '{16, 0, 24, 24, 8},  '{0, 16, 8, 16, 0},  '{16, 16, 24, 24, 8},
        '{0, 16, 24, 24, 8}
    };

    t_seg tenths_glyph [10][NumBytes] = '{
        '{12, 0, 4, 4, 6},  '{0, 0, 0, 4, 2},  '{12, 4, 4, 4, 0},
        '{12, 4, 0, 4, 2},  '{0, 4, 0, 4, 6},  '{12, 4, 0, 0, 6},
        '{12, 4, 4, 0, 6},  '{8, 0, 0, 4, 2},  '{12, 4, 4, 4, 6},
        '{12, 4, 0, 4, 6}
    };

    t_row directed_rows [NumRows] = '{
        '{0,     1, 0, 8,  0,  0,  0, 0},
        '{-4096, 1, 0, 36, 0,  64, 8, 1},
        '{4095,  1, 0, 36, 64, 64, 8, 1},
        '{2000,  1, 0, 36, 64, 64, 8, 1},
        '{-2000, 1, 0, 36, 0,  64, 8, 1},
        '{-4095, 0, 0, 0,  0,  0,  0, 0},
        '{1999,  0, 0, 0,  0,  0,  0, 0},
        '{-1999, 0, 0, 0,  0,  0,  0, 0},
        '{1995,  0, 0, 0,  0,  0,  0, 0},
        '{1000,  0, 0, 0,  0,  0,  0, 0},
        '{-1000, 0, 0, 0,  0,  0,  0, 0},
        '{999,   0, 0, 0,  0,  0,  0, 0},
        '{100,   0, 0, 0,  0,  0,  0, 0},
        '{99,    0, 0, 0,  0,  0,  0, 0},
        '{10,    0, 0, 0,  0,  0,  0, 0},
        '{9,     0, 0, 0,  0,  0,  0, 0},
        '{1,     0, 0, 0,  0,  0,  0, 0},
        '{-1,    0, 0, 0,  0,  0,  0, 0},
        '{1479,  0, 0, 0,  0,  0,  0, 0},
        '{-1479, 0, 0, 0,  0,  0,  0, 0},
        '{1234,  0, 0, 0,  0,  0,  0, 0},
        '{-567,  0, 0, 0,  0,  0,  0, 0},
        '{808,   0, 0, 0,  0,  0,  0, 0}
    };

    t_display expected_displays [$];
    logic     show_sign_model = 1'b1;
    bit       row_typed = 1'b0;
    t_display row_display;
    int       mismatches = 0;
    int       cycle_count = 0;

    function automatic t_display encode_reading(input logic signed [ValueWidth-1:0] v,
                                                input logic sign_on);
        t_display d;
        int mag;
        logic neg;
        neg = v[ValueWidth-1];
        mag = neg ? -int'(v) : int'(v);
        for (int i = 0; i < NumBytes; i++) begin
            d.bytes[i] = '0;
        end
        d.oor = 1'b0;
        if (sign_on) begin
            if (neg) begin
                d.bytes[3] |= 7'd64;
            end else if (mag != 0) begin
                d.bytes[2] |= 7'd64;
                d.bytes[3] |= 7'd64;
            end
        end
        if (mag > 1999) begin
            d.bytes[1] |= 7'd36;
            d.bytes[4] |= 7'd8;
            d.oor = 1'b1;
        end else begin
            if (mag >= 1000) begin
                d.bytes[1] |= 7'd64;
            end
            d.bytes[1] |= 7'd8;
            for (int i = 0; i < NumBytes; i++) begin
                if (mag >= 100) d.bytes[i] |= tens_glyph[(mag / 100) % 10][i];
                if (mag >= 10) d.bytes[i] |= ones_glyph[(mag / 10) % 10][i];
                if (mag >= 1) d.bytes[i] |= tenths_glyph[mag % 10][i];
            end
        end
        return d;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_displays.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // prediction at acceptance, comparison at each result strobe
    always @(posedge i_clk) begin
        t_display want;
        if (!i_rst_n) begin
            show_sign_model = 1'b1;
            expected_displays.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ShowSignAddr) begin
                show_sign_model = pwdata[0];
            end
            if (start && !busy) begin
                if (row_typed) begin
                    expected_displays.push_back(row_display);
                end else begin
                    expected_displays.push_back(encode_reading(i_value_tenths,
                                                               show_sign_model));
                end
            end
            if (o_valid) begin
                if (expected_displays.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none actual %h %h %h %h %h %b",
                             $time, o_seg_byte0, o_seg_byte1, o_seg_byte2, o_seg_byte3,
                             o_seg_byte4, o_out_of_range);
                    mismatches++;
                end else begin
                    want = expected_displays.pop_front();
                    check_field("seg_byte0", want.bytes[0], o_seg_byte0);
                    check_field("seg_byte1", want.bytes[1], o_seg_byte1);
                    check_field("seg_byte2", want.bytes[2], o_seg_byte2);
                    check_field("seg_byte3", want.bytes[3], o_seg_byte3);
                    check_field("seg_byte4", want.bytes[4], o_seg_byte4);
                    check_field("out_of_range", want.oor, o_out_of_range);
                end
            end
        end
    end

    task automatic drive_value(input logic signed [ValueWidth-1:0] v, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_value_tenths <= v;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ApbAddrWidth-1:0] addr,
                             input logic [ApbDataWidth-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_show_sign_reg();
        logic [ApbDataWidth-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ShowSignAddr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        check_field("show_sign readback", {31'b0, show_sign_model}, got);
    endtask

    task automatic drain_results();
        while (expected_displays.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int tmp;
        int gap;
        int burst_left;
        logic [ApbDataWidth-1:0] cfg_data;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_value_tenths = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        check_show_sign_reg();

        for (int r = 0; r < NumRows; r++) begin
            row_typed = directed_rows[r].typed;
            row_display.bytes[0] = t_seg'(directed_rows[r].b0);
            row_display.bytes[1] = t_seg'(directed_rows[r].b1);
            row_display.bytes[2] = t_seg'(directed_rows[r].b2);
            row_display.bytes[3] = t_seg'(directed_rows[r].b3);
            row_display.bytes[4] = t_seg'(directed_rows[r].b4);
            row_display.oor = directed_rows[r].oor;
            drive_value(ValueWidth'(directed_rows[r].value), (r % 4 == 3) ? r % 7 : 0);
        end
        row_typed = 1'b0;
        start <= 1'b0;

        for (int p = 0; p < NumPhases; p++) begin
            drain_results();
            case (p)
                0: cfg_data = 32'h0000_0000;
                1: cfg_data = 32'hFFFF_FFFF;
                2: cfg_data = 32'hFFFF_FFFE;
                3: cfg_data = 32'h0000_0001;
                default: cfg_data = $urandom;
            endcase
            write_reg(ShowSignAddr, cfg_data);
            check_show_sign_reg();
            write_reg(UnmappedAddr, $urandom);
            check_show_sign_reg();

            for (int n = 0; n < ItemsPerPhase; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: tmp = $urandom_range(0, 3998) - 1999;
                    3: tmp = $urandom_range(0, 40) - 20;
                    4, 5: begin
                        case ($urandom_range(0, 4))
                            0: tmp = 10;
                            1: tmp = 100;
                            2: tmp = 1000;
                            3: tmp = 1995;
                            default: tmp = 2000;
                        endcase
                        tmp = tmp + $urandom_range(0, 10) - 5;
                        if ($urandom_range(0, 1) == 1) tmp = -tmp;
                    end
                    default: tmp = $urandom;
                endcase
                if (burst_left > 0) begin
                    burst_left--;
                    gap = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    burst_left = $urandom_range(20, 60);
                    gap = 0;
                end else begin
                    gap = $urandom_range(0, 19);
                end
                drive_value(ValueWidth'(tmp), gap);
            end
            start <= 1'b0;
        end

        while (expected_displays.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== signed_decimal_segment_encoder.f =====
rtl/sdse_pkg.sv
rtl/sdse_enc.sv
rtl/signed_decimal_segment_encoder.sv
bench/signed_decimal_segment_encoder_tb.sv
